// ----- design/mcf_pkg.sv -----
// Package for the motor command frame builder: frame constants, types and CRC step.
`timescale 1ns / 1ps
package mcf_pkg;

  // Direction codes on the command port
  localparam logic [2:0] DirForward = 3'd0;
  localparam logic [2:0] DirLeft    = 3'd1;
  localparam logic [2:0] DirBack    = 3'd2;
  localparam logic [2:0] DirRight   = 3'd3;

  // Fixed frame bytes
  localparam logic [7:0] StartByte = 8'hFF;
  localparam logic [7:0] CmdByte   = 8'h07;
  localparam logic [7:0] SpeedFlag = 8'h01;

  // Control bytes
  localparam logic [7:0] CtrlForward = 8'h50;
  localparam logic [7:0] CtrlLeft    = 8'h10;
  localparam logic [7:0] CtrlBack    = 8'h00;
  localparam logic [7:0] CtrlRight   = 8'h40;
  localparam logic [7:0] CtrlStop    = 8'h00;

  // CRC-16/Modbus
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Frame geometry
  localparam int unsigned FrameLen = 9;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  // Byte positions within the frame
  localparam logic [IdxW-1:0] PosStart  = IdxW'(0);
  localparam logic [IdxW-1:0] PosCmd    = IdxW'(1);
  localparam logic [IdxW-1:0] PosLeft   = IdxW'(2);
  localparam logic [IdxW-1:0] PosFlagL  = IdxW'(3);
  localparam logic [IdxW-1:0] PosRight  = IdxW'(4);
  localparam logic [IdxW-1:0] PosFlagR  = IdxW'(5);
  localparam logic [IdxW-1:0] PosCtrl   = IdxW'(6);
  localparam logic [IdxW-1:0] PosCrcLo  = IdxW'(7);
  localparam logic [IdxW-1:0] PosCrcHi  = IdxW'(8);

  // Decoded command: the three payload bytes that vary
  typedef struct packed {
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [7:0] ctrl;
  } cmd_t;

  // One byte through the reflected CRC, bit at a time (eight narrow steps)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/mcf_decode.sv -----
// Direction decoder: maps a drive command onto control byte and speed bytes.
`timescale 1ns / 1ps
module mcf_decode (
  input  logic [2:0]    direction_i,
  input  logic [7:0]    left_speed_i,
  input  logic [7:0]    right_speed_i,
  output mcf_pkg::cmd_t cmd_o
);
  import mcf_pkg::*;

  // Stop and the unused codes zero both speeds
  always_comb begin
    cmd_o.left_speed  = left_speed_i;
    cmd_o.right_speed = right_speed_i;
    unique case (direction_i)
      DirForward: cmd_o.ctrl = CtrlForward;
      DirLeft:    cmd_o.ctrl = CtrlLeft;
      DirBack:    cmd_o.ctrl = CtrlBack;
      DirRight:   cmd_o.ctrl = CtrlRight;
      default: begin
        cmd_o.ctrl        = CtrlStop;
        cmd_o.left_speed  = 8'h00;
        cmd_o.right_speed = 8'h00;
      end
    endcase
  end

endmodule

// ----- design/mcf_serialiser.sv -----
// Frame serialiser: holds one command, sends nine bytes and folds in the CRC on the way.
`timescale 1ns / 1ps
module mcf_serialiser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  mcf_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          strobe_o,
  output logic [7:0]    frame_byte_o,
  output logic          last_byte_o
);
  import mcf_pkg::*;

  logic            active_q;
  logic [IdxW-1:0] pos_q;
  cmd_t            cmd_q;
  logic [15:0]     crc_q;
  logic [7:0]      byte_d;
  logic            strobe_q;
  logic [7:0]      byte_q;
  logic            last_q;
  logic            at_end;

  assign at_end = (pos_q == PosCrcHi);
  // the last byte only needs the CRC, so the next command may load then
  assign busy_o = active_q && !at_end;

  // Byte select for the current position
  always_comb begin
    case (pos_q)
      PosStart: byte_d = StartByte;
      PosCmd:   byte_d = CmdByte;
      PosLeft:  byte_d = cmd_q.left_speed;
      PosFlagL: byte_d = SpeedFlag;
      PosRight: byte_d = cmd_q.right_speed;
      PosFlagR: byte_d = SpeedFlag;
      PosCtrl:  byte_d = cmd_q.ctrl;
      PosCrcLo: byte_d = crc_q[7:0];
      PosCrcHi: byte_d = crc_q[15:8];
      default:  byte_d = 8'h00;
    endcase
  end

  // Sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= PosStart;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= active_q;
      if (load_i) begin
        active_q <= 1'b1;
        pos_q    <= PosStart;
      end else if (active_q) begin
        pos_q <= pos_q + IdxW'(1);
        if (at_end) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  // Payload: command hold, running CRC and output byte
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= at_end;
    if (active_q && pos_q >= PosCmd && pos_q <= PosCtrl) begin
      crc_q <= crc_byte(crc_q, byte_d);
    end
    if (load_i) begin
      cmd_q <= cmd_i;
      crc_q <= CrcInit;
    end
  end

  assign strobe_o     = strobe_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = strobe_q && last_q;

endmodule

// ----- design/motor_command_frame_crc16.sv -----
// Top level of the motor command frame builder with CRC-16/Modbus trailer.
//
//  channel   handshake          payload                                  direction
//  command   start / busy       direction_i, left_speed_i, right_speed_i in
//  frame     strobe_o           frame_byte_o, last_byte_o                out
//
// A command is taken when start is high and busy is low. Its nine frame bytes
// appear one per cycle on strobe_o, after the sequencer and output registers.
// The byte counter paces the frames; busy drops while the last byte is being
// registered, so the next command is taken then and its frame follows seamlessly.
// The CRC is folded in one byte per cycle as the bytes pass the output stage.
// Reset clears the sequencer; the frame receiver cannot stall.
`timescale 1ns / 1ps
module motor_command_frame_crc16 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] direction_i,
  input  logic [7:0] left_speed_i,
  input  logic [7:0] right_speed_i,
  output logic       strobe_o,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o
);
  import mcf_pkg::*;

  cmd_t cmd;
  logic load;

  // Command transfer
  assign load = start && !busy;

  mcf_decode u_decode (
    .direction_i   (direction_i),
    .left_speed_i  (left_speed_i),
    .right_speed_i (right_speed_i),
    .cmd_o         (cmd)
  );

  mcf_serialiser u_serialiser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .cmd_i        (cmd),
    .busy_o       (busy),
    .strobe_o     (strobe_o),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

// ----- design/mcf_checker.sv -----
// Port-level checker for the motor command frame builder, bound to the top level.
`timescale 1ns / 1ps
module mcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       strobe_o,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o
);

  // A transfer opens a frame with the start byte
  a_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 (strobe_o && frame_byte_o == 8'hFF && !last_byte_o))
    else $error("frame did not open with the start byte");

  // The ninth byte after a transfer carries the last marker
  a_frame_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##9 (strobe_o && last_byte_o))
    else $error("last byte marker missing on the ninth byte");

  // While a frame is in progress a byte is sent in the next cycle
  a_no_gaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> strobe_o)
    else $error("gap in frame bytes while busy");

  // The marker only appears with a byte
  a_last_with_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> strobe_o)
    else $error("last byte marker without a strobe");

endmodule

bind motor_command_frame_crc16 mcf_checker u_mcf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .strobe_o     (strobe_o),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);
